// ===== rtl/core/fmbq_pkg.sv =====
// Shared types, codes and default sizes for the front/middle/back queue.
package fmbq_pkg;

  // Default sizing
  localparam int CAPACITY_DEF    = 1024;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  // Port widths fixed by the interface
  localparam int OP_W     = 3;
  localparam int OUT_W    = 32;
  localparam int IN_W     = 32;
  localparam int STATUS_W = 2;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_MID   = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_MID    = 3'd4;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Position within the sequence
  localparam logic [1:0] POS_FRONT = 2'd0;
  localparam logic [1:0] POS_MID   = 2'd1;
  localparam logic [1:0] POS_BACK  = 2'd2;

  // Classified command handed from the front end to the executor
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [1:0] pos;
  } cmd_t;

endpackage

// ===== rtl/core/fmbq_decode.sv =====
// Front end: accepts input transactions and classifies the opcode.
module fmbq_decode import fmbq_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic signed [IN_W-1:0]  in_push_value,
  output logic                    q_valid,
  input  logic                    q_ready,
  output cmd_t                    q_cmd,
  output logic [VALUE_WIDTH-1:0]  q_value
);

  // Handshake passes straight into the command queue
  assign q_valid  = in_valid;
  assign in_ready = q_ready;

  // Value is kept at storage width
  assign q_value = VALUE_WIDTH'(in_push_value);

  // Opcode classification; unused codes become a no-op
  always_comb begin
    q_cmd = '0;
    case (in_opcode)
      OP_PUSH_FRONT: begin q_cmd.push = 1'b1; q_cmd.pos = POS_FRONT; end
      OP_PUSH_MID:   begin q_cmd.push = 1'b1; q_cmd.pos = POS_MID;   end
      OP_PUSH_BACK:  begin q_cmd.push = 1'b1; q_cmd.pos = POS_BACK;  end
      OP_POP_FRONT:  begin q_cmd.pop  = 1'b1; q_cmd.pos = POS_FRONT; end
      OP_POP_MID:    begin q_cmd.pop  = 1'b1; q_cmd.pos = POS_MID;   end
      OP_POP_BACK:   begin q_cmd.pop  = 1'b1; q_cmd.pos = POS_BACK;  end
      default:       q_cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/fmbq_cmd_fifo.sv =====
// Short command queue between the front end and the executor.
module fmbq_cmd_fifo import fmbq_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointer and occupancy update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/fmbq_exec.sv =====
// Back end: holds both half rings, carries out commands and registers results.
module fmbq_exec import fmbq_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  cmd_t                       cmd,
  input  logic [VALUE_WIDTH-1:0]     cmd_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_W-1:0]    out_pop_value,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
  localparam int AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int CW = $clog2(HALF_DEPTH + 1);
  localparam int SW = CW + 1;

  // Executor states
  localparam logic S_IDLE  = 1'b0;
  localparam logic S_WRITE = 1'b1;

  // Write data select
  localparam logic WSEL_VAL  = 1'b0;
  localparam logic WSEL_XFER = 1'b1;

  // Result select
  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_NEG1 = 2'd1;
  localparam logic [1:0] RES_FRD  = 2'd2;
  localparam logic [1:0] RES_BRD  = 2'd3;

  // Ring index arithmetic
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(HALF_DEPTH)) begin
      s = s - SW'(HALF_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] base);
    return (base == '0) ? AW'(HALF_DEPTH - 1) : base - AW'(1);
  endfunction

  // Ring state
  logic          state_r, state_nxt;
  logic [AW-1:0] fh_r, fh_nxt, bh_r, bh_nxt;
  logic [CW-1:0] fc_r, fc_nxt, bc_r, bc_nxt;

  // Planned write phase
  logic                   f_we_r, f_we_nxt, b_we_r, b_we_nxt;
  logic [AW-1:0]          f_waddr_r, f_waddr_nxt, b_waddr_r, b_waddr_nxt;
  logic                   f_wsel_r, f_wsel_nxt, b_wsel_r, b_wsel_nxt;
  logic [1:0]             res_sel_r, res_sel_nxt;
  logic [STATUS_W-1:0]    st_r, st_nxt;
  logic [VALUE_WIDTH-1:0] val_r;

  // Half memories and their read ports
  logic [VALUE_WIDTH-1:0] fmem [HALF_DEPTH];
  logic [VALUE_WIDTH-1:0] bmem [HALF_DEPTH];
  logic [VALUE_WIDTH-1:0] f_rd_r, b_rd_r;
  logic signed [VALUE_WIDTH-1:0] f_rd_s, b_rd_s;
  logic [AW-1:0]          f_raddr, b_raddr;
  logic [VALUE_WIDTH-1:0] f_wdata, b_wdata;

  // Output register
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] pop_value_r, pop_value_nxt;
  logic [STATUS_W-1:0]     status_r;

  logic          take, slot_free, commit, unbal, full;
  logic [AW-1:0] f_front, f_back, f_tail, f_pre, f_inc;
  logic [AW-1:0] b_front, b_back, b_tail, b_pre, b_inc;

  assign cmd_ready = (state_r == S_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign commit    = (state_r == S_WRITE) && slot_free;

  // Ring positions from the current heads and counts
  assign f_front = fh_r;
  assign f_back  = wrap_add(fh_r, fc_r - CW'(1));
  assign f_tail  = wrap_add(fh_r, fc_r);
  assign f_pre   = wrap_dec(fh_r);
  assign f_inc   = wrap_add(fh_r, CW'(1));
  assign b_front = bh_r;
  assign b_back  = wrap_add(bh_r, bc_r - CW'(1));
  assign b_tail  = wrap_add(bh_r, bc_r);
  assign b_pre   = wrap_dec(bh_r);
  assign b_inc   = wrap_add(bh_r, CW'(1));

  assign unbal = (fc_r != bc_r);
  assign full  = (SW'(fc_r) + SW'(bc_r)) >= SW'(CAPACITY);

  // Plan: read addresses, pointer updates and the writes for the write phase
  always_comb begin
    fh_nxt      = fh_r;
    fc_nxt      = fc_r;
    bh_nxt      = bh_r;
    bc_nxt      = bc_r;
    f_raddr     = f_back;
    b_raddr     = b_front;
    f_we_nxt    = 1'b0;
    f_waddr_nxt = f_tail;
    f_wsel_nxt  = WSEL_VAL;
    b_we_nxt    = 1'b0;
    b_waddr_nxt = b_tail;
    b_wsel_nxt  = WSEL_VAL;
    res_sel_nxt = RES_ZERO;
    st_nxt      = ST_OK;
    if (cmd.push) begin
      if (full) begin
        st_nxt = ST_FULL;
      end else begin
        case (cmd.pos)
          POS_FRONT: begin
            // front half's last element shifts over when it is the longer one
            if (unbal) begin
              b_we_nxt    = 1'b1;
              b_waddr_nxt = b_pre;
              b_wsel_nxt  = WSEL_XFER;
              bh_nxt      = b_pre;
              bc_nxt      = bc_r + CW'(1);
            end else begin
              fc_nxt = fc_r + CW'(1);
            end
            f_we_nxt    = 1'b1;
            f_waddr_nxt = f_pre;
            fh_nxt      = f_pre;
          end
          POS_MID: begin
            // on shift the new value takes the slot just vacated
            f_we_nxt = 1'b1;
            if (unbal) begin
              b_we_nxt    = 1'b1;
              b_waddr_nxt = b_pre;
              b_wsel_nxt  = WSEL_XFER;
              bh_nxt      = b_pre;
              bc_nxt      = bc_r + CW'(1);
              f_waddr_nxt = f_back;
            end else begin
              fc_nxt = fc_r + CW'(1);
            end
          end
          POS_BACK: begin
            if (unbal) begin
              b_we_nxt = 1'b1;
              bc_nxt   = bc_r + CW'(1);
            end else begin
              // back half's first element moves to the front half's tail
              f_we_nxt = 1'b1;
              fc_nxt   = fc_r + CW'(1);
              bh_nxt   = b_inc;
              if (bc_r != '0) begin
                f_wsel_nxt = WSEL_XFER;
                b_we_nxt   = 1'b1;
              end
            end
          end
          default: st_nxt = ST_OK;
        endcase
      end
    end else if (cmd.pop) begin
      if (fc_r == '0) begin
        res_sel_nxt = RES_NEG1;
        st_nxt      = ST_EMPTY;
      end else begin
        case (cmd.pos)
          POS_FRONT: begin
            f_raddr     = f_front;
            res_sel_nxt = RES_FRD;
            fh_nxt      = f_inc;
            if (!unbal) begin
              f_we_nxt    = 1'b1;
              f_wsel_nxt  = WSEL_XFER;
              bh_nxt      = b_inc;
              bc_nxt      = bc_r - CW'(1);
            end else begin
              fc_nxt = fc_r - CW'(1);
            end
          end
          POS_MID: begin
            res_sel_nxt = RES_FRD;
            if (!unbal) begin
              f_we_nxt    = 1'b1;
              f_waddr_nxt = f_back;
              f_wsel_nxt  = WSEL_XFER;
              bh_nxt      = b_inc;
              bc_nxt      = bc_r - CW'(1);
            end else begin
              fc_nxt = fc_r - CW'(1);
            end
          end
          POS_BACK: begin
            if (bc_r == '0) begin
              // single element sits in the front half
              res_sel_nxt = RES_FRD;
              fc_nxt      = fc_r - CW'(1);
            end else begin
              b_raddr     = b_back;
              res_sel_nxt = RES_BRD;
              if (unbal) begin
                fc_nxt      = fc_r - CW'(1);
                b_we_nxt    = 1'b1;
                b_waddr_nxt = b_pre;
                b_wsel_nxt  = WSEL_XFER;
                bh_nxt      = b_pre;
              end else begin
                bc_nxt = bc_r - CW'(1);
              end
            end
          end
          default: st_nxt = ST_OK;
        endcase
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (take) state_nxt = S_WRITE;
      S_WRITE: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fh_r        <= '0;
      fc_r        <= '0;
      bh_r        <= '0;
      bc_r        <= '0;
      f_we_r      <= 1'b0;
      b_we_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take) begin
        fh_r   <= fh_nxt;
        fc_r   <= fc_nxt;
        bh_r   <= bh_nxt;
        bc_r   <= bc_nxt;
        f_we_r <= f_we_nxt;
        b_we_r <= b_we_nxt;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Plan and result payload
  always_ff @(posedge clk) begin
    if (take) begin
      f_waddr_r <= f_waddr_nxt;
      f_wsel_r  <= f_wsel_nxt;
      b_waddr_r <= b_waddr_nxt;
      b_wsel_r  <= b_wsel_nxt;
      res_sel_r <= res_sel_nxt;
      st_r      <= st_nxt;
      val_r     <= cmd_value;
    end
    if (commit) begin
      pop_value_r <= pop_value_nxt;
      status_r    <= st_r;
    end
  end

  // Half memories: read on accept, write when the result is committed
  assign f_wdata = (f_wsel_r == WSEL_XFER) ? b_rd_r : val_r;
  assign b_wdata = (b_wsel_r == WSEL_XFER) ? f_rd_r : val_r;

  always_ff @(posedge clk) begin
    if (commit && f_we_r) begin
      fmem[f_waddr_r] <= f_wdata;
    end
    if (take) begin
      f_rd_r <= fmem[f_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (commit && b_we_r) begin
      bmem[b_waddr_r] <= b_wdata;
    end
    if (take) begin
      b_rd_r <= bmem[b_raddr];
    end
  end

  // Result value, sign extended from storage width
  assign f_rd_s = f_rd_r;
  assign b_rd_s = b_rd_r;

  always_comb begin
    case (res_sel_r)
      RES_ZERO: pop_value_nxt = '0;
      RES_NEG1: pop_value_nxt = '1;
      RES_FRD:  pop_value_nxt = OUT_W'(f_rd_s);
      RES_BRD:  pop_value_nxt = OUT_W'(b_rd_s);
      default:  pop_value_nxt = '0;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = pop_value_r;
  assign out_status    = status_r;

  // Front half is never shorter than the back half, nor longer by two
  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (fc_r == bc_r) || (fc_r == bc_r + CW'(1)))
    else $error("half counts out of balance");

  // Total never exceeds capacity
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    (SW'(fc_r) + SW'(bc_r)) <= SW'(CAPACITY))
    else $error("element count above capacity");

  // A new result only appears out of the write phase
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WRITE))
    else $error("result without write phase");

  // Empty pop reports minus one
  a_empty_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_EMPTY) |-> (pop_value_r == '1))
    else $error("empty pop with wrong value");

  // No command is taken while a write phase is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !take)
    else $error("command taken during write phase");

endmodule

// ===== rtl/core/front_middle_back_queue.sv =====
// Top level of the front/middle/back queue: decode, command queue, executor.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in      | input     | in_valid / in_ready | in_opcode, in_push_value
//   out     | output    | out_valid/out_ready | out_pop_value, out_status
//
// For each transaction the executor reads both half memories at the
// planned addresses, then writes them back and registers the result once
// the output register is free; it takes no new command until that write
// is done. The front end takes one transaction a cycle into a two-entry
// queue while it has room, so input stays open while a result waits at
// the output register until that queue fills.
// Synchronous active-low reset empties both halves; memory contents are
// not cleared and need no clearing pass.
module front_middle_back_queue import fmbq_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_opcode,
  input  logic signed [IN_W-1:0]     in_push_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_W-1:0]    out_pop_value,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int QW    = CMD_W + VALUE_WIDTH;

  logic                   dec_valid, dec_ready;
  cmd_t                   dec_cmd;
  logic [VALUE_WIDTH-1:0] dec_value;
  logic [QW-1:0]          q_wdata, q_rdata;
  logic                   ex_valid, ex_ready;
  cmd_t                   ex_cmd;
  logic [VALUE_WIDTH-1:0] ex_value;

  // Opcode classification
  fmbq_decode #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_decode (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_push_value (in_push_value),
    .q_valid       (dec_valid),
    .q_ready       (dec_ready),
    .q_cmd         (dec_cmd),
    .q_value       (dec_value)
  );

  // Command queue
  assign q_wdata = {dec_cmd, dec_value};
  assign {ex_cmd, ex_value} = q_rdata;

  fmbq_cmd_fifo #(
    .WIDTH(QW)
  ) u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (dec_valid),
    .wr_ready (dec_ready),
    .wr_data  (q_wdata),
    .rd_valid (ex_valid),
    .rd_ready (ex_ready),
    .rd_data  (q_rdata)
  );

  // Executor with both half rings
  fmbq_exec #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_exec (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (ex_valid),
    .cmd_ready     (ex_ready),
    .cmd           (ex_cmd),
    .cmd_value     (ex_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pop_value (out_pop_value),
    .out_status    (out_status)
  );

endmodule
